>>> hw/rtl/arpr_pkg.sv
// Shared types, codes and helpers of the ARP resolver.
`default_nettype none
package arpr_pkg;

	localparam int unsigned CACHE_ENTRIES_DEF = 16;
	localparam int unsigned PENDING_IPS_DEF   = 8;
	localparam int unsigned QUEUE_DEPTH_DEF   = 8;

	localparam logic [15:0] ENTRY_EXPIRY_RST   = 16'd30000;
	localparam logic [15:0] REQUEST_EXPIRY_RST = 16'd5000;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] OP_SEND   = 2'd0;
	localparam logic [1:0] OP_RECV   = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] FT_IPV4  = 2'd0;
	localparam logic [1:0] FT_ARP   = 2'd1;
	localparam logic [1:0] FT_OTHER = 2'd2;

	localparam logic [1:0] REG_OWN_MAC   = 2'd0;
	localparam logic [1:0] REG_OWN_IP    = 2'd1;
	localparam logic [1:0] REG_ENTRY_EXP = 2'd2;
	localparam logic [1:0] REG_REQ_EXP   = 2'd3;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_IPV4    = 3'd1;
	localparam logic [2:0] KIND_ARP_REQ = 3'd2;
	localparam logic [2:0] KIND_ARP_REP = 3'd3;
	localparam logic [2:0] KIND_DELIVER = 3'd4;
	localparam logic [2:0] KIND_QUEUED  = 3'd5;
	localparam logic [2:0] KIND_DROPPED = 3'd6;

	typedef enum logic [2:0] {
		CL_NONE,
		CL_DELIVER,
		CL_SEND,
		CL_ARP,
		CL_TICK
	} class_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] route_ip;
		logic [7:0]  dgram_handle;
		logic [47:0] frame_dst_mac;
		logic [1:0]  frame_type;
		logic        payload_ok;
		logic        arp_is_request;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_sender_ip;
		logic [31:0] arp_target_ip;
		logic [15:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		class_t cls;
		item_t  item;
	} front_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] dst_mac;
		logic [31:0] arp_target_addr;
		logic [7:0]  out_handle;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		logic [15:0] entry_expiry_ms;
		logic [15:0] request_expiry_ms;
	} cfg_t;

	function automatic result_t make_result(input logic [2:0] kind, input logic [47:0] mac,
			input logic [31:0] tip, input logic [7:0] h, input logic last);
		result_t r;
		r.kind            = kind;
		r.dst_mac         = mac;
		r.arp_target_addr = tip;
		r.out_handle      = h;
		r.last            = last;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/arpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arpr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/arpr_fifo.sv
// Small register FIFO used between the front, the engine and the result port.
`default_nettype none
module arpr_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= CW'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/arpr_front.sv
// Input side: takes items, classifies them and queues them for the engine.
`default_nettype none
module arpr_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire arpr_pkg::cfg_t        cfg,
	input  wire logic                  push,
	input  wire arpr_pkg::item_t       item,
	output logic                       full,
	input  wire logic                  pop,
	output arpr_pkg::front_item_t      head,
	output logic                       empty
);

	arpr_pkg::class_t      cls;
	arpr_pkg::front_item_t fi;
	logic                  for_us;

	always_comb begin
		for_us = (item.frame_dst_mac == cfg.own_mac) ||
			(item.frame_dst_mac == arpr_pkg::BCAST_MAC);
		case (item.opcode)
			arpr_pkg::OP_SEND: cls = arpr_pkg::CL_SEND;
			arpr_pkg::OP_TICK: cls = arpr_pkg::CL_TICK;
			arpr_pkg::OP_RECV: begin
				if (!for_us || !item.payload_ok) begin
					cls = arpr_pkg::CL_NONE;
				end else if (item.frame_type == arpr_pkg::FT_IPV4) begin
					cls = arpr_pkg::CL_DELIVER;
				end else if (item.frame_type == arpr_pkg::FT_ARP &&
						item.arp_target_ip == cfg.own_ip) begin
					cls = arpr_pkg::CL_ARP;
				end else begin
					cls = arpr_pkg::CL_NONE;
				end
			end
			default: cls = arpr_pkg::CL_NONE;
		endcase
		fi.cls  = cls;
		fi.item = item;
	end

	arpr_fifo #(
		.WIDTH($bits(arpr_pkg::front_item_t)),
		.DEPTH(2)
	) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (fi),
		.full  (full),
		.rd    (pop),
		.rdata (head),
		.empty (empty)
	);

endmodule
`default_nettype wire

>>> hw/rtl/arpr_engine.sv
// Back end: walks the cache and pending tables and produces results.
`default_nettype none
module arpr_engine #(
	parameter int unsigned CACHE_ENTRIES = arpr_pkg::CACHE_ENTRIES_DEF,
	parameter int unsigned PENDING_IPS   = arpr_pkg::PENDING_IPS_DEF,
	parameter int unsigned QUEUE_DEPTH   = arpr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire arpr_pkg::cfg_t        cfg,
	input  wire arpr_pkg::front_item_t head,
	input  wire logic                  head_valid,
	output logic                       head_pop,
	output arpr_pkg::result_t          res,
	output logic                       res_push,
	input  wire logic                  res_full
);

	localparam int unsigned WALK_N = (CACHE_ENTRIES > PENDING_IPS) ? CACHE_ENTRIES : PENDING_IPS;
	localparam int unsigned WW   = (WALK_N > 1) ? $clog2(WALK_N) : 1;
	localparam int unsigned CIW  = $clog2(CACHE_ENTRIES);
	localparam int unsigned PIW  = (PENDING_IPS > 1) ? $clog2(PENDING_IPS) : 1;
	localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned HD   = PENDING_IPS * QUEUE_DEPTH;
	localparam int unsigned AW   = (HD > 1) ? $clog2(HD) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_WALK, S_SEND, S_QUEUE, S_REQ, S_LEARN, S_RD, S_REL, S_TAIL, S_ONE
	} state_t;

	state_t state_q;
	logic [WW-1:0] w_q;
	arpr_pkg::class_t cls_q;
	arpr_pkg::item_t  it_q;

	logic        cache_valid_q [CACHE_ENTRIES];
	logic [31:0] cache_ip_q    [CACHE_ENTRIES];
	logic [47:0] cache_mac_q   [CACHE_ENTRIES];
	logic [15:0] cache_age_q   [CACHE_ENTRIES];
	logic        pend_valid_q  [PENDING_IPS];
	logic [31:0] pend_ip_q     [PENDING_IPS];
	logic        req_out_q     [PENDING_IPS];
	logic [15:0] req_age_q     [PENDING_IPS];
	logic [CNTW-1:0] qcnt_q    [PENDING_IPS];

	logic            hit_q, cfree_q, pm_q, pfree_q, rel_q;
	logic [47:0]     mac_q;
	logic [CIW-1:0]  cfree_idx_q, old_idx_q;
	logic [15:0]     old_age_q;
	logic [PIW-1:0]  p_q, pfree_idx_q;
	logic [CNTW-1:0] p_cnt_q, k_q;
	logic            p_req_q;
	arpr_pkg::result_t res_q;

	logic [CIW-1:0] ci;
	logic [PIW-1:0] pi;
	logic           c_in, p_in, walk_end;
	logic [31:0]    key;
	logic [16:0]    c_sum, r_sum;
	logic [CIW-1:0] victim;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_rdata;
	logic           rel_end;

	assign ci       = w_q[CIW-1:0];
	assign pi       = PIW'(w_q);
	assign c_in     = 32'(w_q) < CACHE_ENTRIES;
	assign p_in     = 32'(w_q) < PENDING_IPS;
	assign walk_end = 32'(w_q) == WALK_N - 1;
	assign key      = (cls_q == arpr_pkg::CL_SEND) ? it_q.route_ip : it_q.arp_sender_ip;
	assign c_sum    = 17'(cache_age_q[ci]) + 17'(it_q.elapsed_ms);
	assign r_sum    = 17'(req_age_q[pi]) + 17'(it_q.elapsed_ms);
	assign victim   = cfree_q ? cfree_idx_q : old_idx_q;
	assign rel_end  = CNTW'(k_q + 1'b1) == p_cnt_q;
	assign head_pop = (state_q == S_IDLE) && head_valid;

	assign ram_we    = (state_q == S_QUEUE) && !res_full &&
		(p_cnt_q < CNTW'(QUEUE_DEPTH));
	assign ram_waddr = AW'(AW'(p_q) * AW'(QUEUE_DEPTH) + AW'(p_cnt_q));
	assign ram_raddr = AW'(AW'(p_q) * AW'(QUEUE_DEPTH) + AW'(k_q));

	arpr_ram #(.WIDTH(8), .DEPTH(HD)) u_handles (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(it_q.dgram_handle),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_push = 1'b0;
		res      = res_q;
		case (state_q)
			S_QUEUE: begin
				res_push = !res_full;
				res = arpr_pkg::make_result(
					(p_cnt_q >= CNTW'(QUEUE_DEPTH)) ? arpr_pkg::KIND_DROPPED
						: arpr_pkg::KIND_QUEUED,
					48'd0, 32'd0, it_q.dgram_handle, p_req_q);
			end
			S_REQ: begin
				res_push = !res_full;
				res = arpr_pkg::make_result(arpr_pkg::KIND_ARP_REQ, arpr_pkg::BCAST_MAC,
					key, 8'd0, 1'b1);
			end
			S_REL: begin
				res_push = !res_full;
				res = arpr_pkg::make_result(arpr_pkg::KIND_IPV4, mac_q, 32'd0, ram_rdata,
					rel_end && !it_q.arp_is_request);
			end
			S_TAIL: begin
				res_push = it_q.arp_is_request && !res_full;
				res = arpr_pkg::make_result(arpr_pkg::KIND_ARP_REP, it_q.arp_sender_mac,
					it_q.arp_sender_ip, 8'd0, 1'b1);
			end
			S_ONE: begin
				res_push = !res_full;
				res      = res_q;
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= '0;
			k_q     <= '0;
			hit_q   <= 1'b0;
			cfree_q <= 1'b0;
			pm_q    <= 1'b0;
			pfree_q <= 1'b0;
			rel_q   <= 1'b0;
			p_req_q <= 1'b0;
			p_cnt_q <= '0;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				cache_valid_q[i] <= 1'b0;
			end
			for (int i = 0; i < PENDING_IPS; i++) begin
				pend_valid_q[i] <= 1'b0;
				req_out_q[i]    <= 1'b0;
				qcnt_q[i]       <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						it_q    <= head.item;
						cls_q   <= head.cls;
						w_q     <= '0;
						hit_q   <= 1'b0;
						cfree_q <= 1'b0;
						pm_q    <= 1'b0;
						pfree_q <= 1'b0;
						rel_q   <= 1'b0;
						case (head.cls)
							arpr_pkg::CL_DELIVER: begin
								res_q <= arpr_pkg::make_result(arpr_pkg::KIND_DELIVER, 48'd0,
									32'd0, head.item.dgram_handle, 1'b1);
								state_q <= S_ONE;
							end
							arpr_pkg::CL_SEND, arpr_pkg::CL_ARP, arpr_pkg::CL_TICK:
								state_q <= S_WALK;
							default: begin
								res_q <= arpr_pkg::make_result(arpr_pkg::KIND_NONE, 48'd0,
									32'd0, 8'd0, 1'b1);
								state_q <= S_ONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (c_in) begin
						if (cls_q == arpr_pkg::CL_TICK) begin
							if (cache_valid_q[ci]) begin
								if (c_sum > {1'b0, cfg.entry_expiry_ms}) begin
									cache_valid_q[ci] <= 1'b0;
								end else begin
									cache_age_q[ci] <= c_sum[15:0];
								end
							end
						end else begin
							if (cache_valid_q[ci] && cache_ip_q[ci] == key && !hit_q) begin
								hit_q <= 1'b1;
								mac_q <= cache_mac_q[ci];
							end
							if (!cache_valid_q[ci] && !cfree_q) begin
								cfree_q     <= 1'b1;
								cfree_idx_q <= ci;
							end
							// strict compare keeps the lowest index on equal ages
							if (w_q == '0 || cache_age_q[ci] > old_age_q) begin
								old_age_q <= cache_age_q[ci];
								old_idx_q <= ci;
							end
						end
					end
					if (p_in) begin
						if (cls_q == arpr_pkg::CL_TICK) begin
							if (pend_valid_q[pi] && req_out_q[pi]) begin
								if (r_sum > {1'b0, cfg.request_expiry_ms}) begin
									req_out_q[pi] <= 1'b0;
									if (qcnt_q[pi] == '0) begin
										pend_valid_q[pi] <= 1'b0;
									end
								end else begin
									req_age_q[pi] <= r_sum[15:0];
								end
							end
						end else begin
							if (pend_valid_q[pi] && pend_ip_q[pi] == key && !pm_q) begin
								pm_q    <= 1'b1;
								p_q     <= pi;
								p_cnt_q <= qcnt_q[pi];
								p_req_q <= req_out_q[pi];
							end
							if (!pend_valid_q[pi] && !pfree_q) begin
								pfree_q     <= 1'b1;
								pfree_idx_q <= pi;
							end
						end
					end
					w_q <= WW'(w_q + 1'b1);
					if (walk_end) begin
						case (cls_q)
							arpr_pkg::CL_SEND: state_q <= S_SEND;
							arpr_pkg::CL_ARP:  state_q <= S_LEARN;
							default: begin
								res_q <= arpr_pkg::make_result(arpr_pkg::KIND_NONE, 48'd0,
									32'd0, 8'd0, 1'b1);
								state_q <= S_ONE;
							end
						endcase
					end
				end
				S_SEND: begin
					if (hit_q) begin
						res_q <= arpr_pkg::make_result(arpr_pkg::KIND_IPV4, mac_q, 32'd0,
							it_q.dgram_handle, 1'b1);
						state_q <= S_ONE;
					end else if (!pm_q && !pfree_q) begin
						res_q <= arpr_pkg::make_result(arpr_pkg::KIND_DROPPED, 48'd0, 32'd0,
							it_q.dgram_handle, 1'b1);
						state_q <= S_ONE;
					end else begin
						if (!pm_q) begin
							pend_valid_q[pfree_idx_q] <= 1'b1;
							pend_ip_q[pfree_idx_q]    <= key;
							req_out_q[pfree_idx_q]    <= 1'b0;
							qcnt_q[pfree_idx_q]       <= '0;
							p_q     <= pfree_idx_q;
							p_cnt_q <= '0;
							p_req_q <= 1'b0;
						end
						state_q <= S_QUEUE;
					end
				end
				S_QUEUE: begin
					if (!res_full) begin
						if (ram_we) begin
							qcnt_q[p_q] <= CNTW'(p_cnt_q + 1'b1);
							p_cnt_q     <= CNTW'(p_cnt_q + 1'b1);
						end
						state_q <= p_req_q ? S_IDLE : S_REQ;
					end
				end
				S_REQ: begin
					if (!res_full) begin
						req_out_q[p_q] <= 1'b1;
						req_age_q[p_q] <= 16'd0;
						state_q        <= S_IDLE;
					end
				end
				S_LEARN: begin
					if (!hit_q) begin
						cache_valid_q[victim] <= 1'b1;
						cache_ip_q[victim]    <= it_q.arp_sender_ip;
						cache_mac_q[victim]   <= it_q.arp_sender_mac;
						cache_age_q[victim]   <= 16'd0;
						mac_q                 <= it_q.arp_sender_mac;
					end
					k_q <= '0;
					state_q <= (pm_q && p_cnt_q != '0) ? S_RD : S_TAIL;
				end
				S_RD: state_q <= S_REL;
				S_REL: begin
					if (!res_full) begin
						k_q <= CNTW'(k_q + 1'b1);
						if (rel_end) begin
							rel_q   <= 1'b1;
							state_q <= S_TAIL;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_TAIL: begin
					if (it_q.arp_is_request) begin
						if (!res_full) begin
							if (pm_q) begin
								qcnt_q[p_q] <= '0;
								if (!p_req_q) begin
									pend_valid_q[p_q] <= 1'b0;
								end
							end
							state_q <= S_IDLE;
						end
					end else begin
						if (pm_q) begin
							qcnt_q[p_q]       <= '0;
							req_out_q[p_q]    <= 1'b0;
							pend_valid_q[p_q] <= 1'b0;
						end
						res_q <= arpr_pkg::make_result(arpr_pkg::KIND_NONE, 48'd0, 32'd0,
							8'd0, 1'b1);
						state_q <= rel_q ? S_IDLE : S_ONE;
					end
				end
				S_ONE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");
	a_release_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL) |-> (k_q < p_cnt_q)) else $error("release index past count");
	a_queue_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QUEUE) |-> (32'(p_cnt_q) <= QUEUE_DEPTH))
		else $error("pending queue count overflow");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |=> (state_q != S_IDLE)) else $error("item taken but engine stayed idle");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/arp_resolver_with_pending_queue_top.sv
// Top level of the ARP resolver: configuration registers, front, engine, result queue.
`default_nettype none
// ARP resolver with per-address pending queues. Items go in through a queue-style
// push/full port and results come out through empty/pop, oldest first; every item
// yields one or more results and the final one carries last. Items are handled one
// at a time by a table-walking engine: after it picks an item up, each send, ARP or
// tick item walks max(CACHE_ENTRIES, PENDING_IPS) entries at one per cycle, then
// emits its results; each released queued handle is read from the handle RAM, which
// has a registered read. Delivered frames and ignored items skip the walk. A full
// result queue stalls the engine.
// A two-entry queue at each side lets the producer and the consumer stall freely.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
module arp_resolver_with_pending_queue_top #(
	parameter int unsigned CACHE_ENTRIES = arpr_pkg::CACHE_ENTRIES_DEF,
	parameter int unsigned PENDING_IPS   = arpr_pkg::PENDING_IPS_DEF,
	parameter int unsigned QUEUE_DEPTH   = arpr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] route_ip,
	input  wire logic [7:0]  dgram_handle,
	input  wire logic [47:0] frame_dst_mac,
	input  wire logic [1:0]  frame_type,
	input  wire logic        payload_ok,
	input  wire logic        arp_is_request,
	input  wire logic [47:0] arp_sender_mac,
	input  wire logic [31:0] arp_sender_ip,
	input  wire logic [31:0] arp_target_ip,
	input  wire logic [15:0] elapsed_ms,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [47:0]      dst_mac,
	output logic [31:0]      arp_target_addr,
	output logic [7:0]       out_handle,
	output logic             last
);

	arpr_pkg::cfg_t        cfg_q;
	arpr_pkg::item_t       item;
	arpr_pkg::front_item_t head;
	arpr_pkg::result_t     eng_res, out_res;
	logic                  head_empty, head_pop, res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac           <= '0;
			cfg_q.own_ip            <= '0;
			cfg_q.entry_expiry_ms   <= arpr_pkg::ENTRY_EXPIRY_RST;
			cfg_q.request_expiry_ms <= arpr_pkg::REQUEST_EXPIRY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				arpr_pkg::REG_OWN_MAC:   cfg_q.own_mac           <= cfg_data;
				arpr_pkg::REG_OWN_IP:    cfg_q.own_ip            <= cfg_data[31:0];
				arpr_pkg::REG_ENTRY_EXP: cfg_q.entry_expiry_ms   <= cfg_data[15:0];
				arpr_pkg::REG_REQ_EXP:   cfg_q.request_expiry_ms <= cfg_data[15:0];
				default:                 cfg_q                   <= cfg_q;
			endcase
		end
	end

	always_comb begin
		item.opcode         = opcode;
		item.route_ip       = route_ip;
		item.dgram_handle   = dgram_handle;
		item.frame_dst_mac  = frame_dst_mac;
		item.frame_type     = frame_type;
		item.payload_ok     = payload_ok;
		item.arp_is_request = arp_is_request;
		item.arp_sender_mac = arp_sender_mac;
		item.arp_sender_ip  = arp_sender_ip;
		item.arp_target_ip  = arp_target_ip;
		item.elapsed_ms     = elapsed_ms;
	end

	arpr_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.push  (push),
		.item  (item),
		.full  (full),
		.pop   (head_pop),
		.head  (head),
		.empty (head_empty)
	);

	arpr_engine #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.PENDING_IPS  (PENDING_IPS),
		.QUEUE_DEPTH  (QUEUE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.head_valid(!head_empty),
		.head_pop  (head_pop),
		.res       (eng_res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	arpr_fifo #(
		.WIDTH($bits(arpr_pkg::result_t)),
		.DEPTH(2)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (eng_res),
		.full  (res_full),
		.rd    (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign kind            = out_res.kind;
	assign dst_mac         = out_res.dst_mac;
	assign arp_target_addr = out_res.arp_target_addr;
	assign out_handle      = out_res.out_handle;
	assign last            = out_res.last;

endmodule
`default_nettype wire
